// File: design/lbpa_pkg.sv
`timescale 1ns / 1ps

package lbpa_pkg;

  // Pool geometry
  localparam int NUM_OBJECTS  = 256;
  localparam int HEADER_BYTES = 24;
  localparam int MAX_SEGS     = 64;

  // Field widths
  localparam int OBJ_W   = 8;
  localparam int COUNT_W = 16;
  localparam int POS_W   = 16;
  localparam int LEN_W   = 15;
  localparam int OFF_W   = 17;
  localparam int CUR_W   = 18;
  localparam int BSZ_W   = 15;
  localparam int MASK_W  = 14;
  localparam int SHIFT_W = 4;
  localparam int REF_W   = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 17;

  // Derived widths
  localparam int IDX_W  = $clog2(NUM_OBJECTS);
  localparam int FREE_W = $clog2(NUM_OBJECTS + 1);
  localparam int SEG_W  = $clog2(MAX_SEGS);

  // Register limits and reset values
  localparam logic [SHIFT_W-1:0] SHIFT_MIN   = 4'd10;
  localparam logic [SHIFT_W-1:0] SHIFT_MAX   = 4'd14;
  localparam logic [SHIFT_W-1:0] SHIFT_RESET = 4'd12;
  localparam logic [OFF_W-1:0]   LIMIT_CAP   = 17'd65536;
  localparam logic [OFF_W-1:0]   LIMIT_RESET = 17'd65472;
  localparam logic [REF_W-1:0]   REF_MAX     = 8'd255;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SHIFT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_LIMIT  = 1'b1;

  typedef enum logic [2:0] {
    ACT_ALLOC   = 3'd0,
    ACT_HOLD    = 3'd1,
    ACT_RELEASE = 3'd2,
    ACT_APPEND  = 3'd3,
    ACT_REWIND  = 3'd4
  } action_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_POOL_EMPTY = 3'd1,
    ST_NO_SPACE   = 3'd2,
    ST_NOT_HELD   = 3'd3,
    ST_SATURATED  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_CHECK,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic [2:0]         action;
    logic [OBJ_W-1:0]   object;
    logic [COUNT_W-1:0] count;
    logic               mark_empty;
  } item_t;

  typedef struct packed {
    status_t            status;
    logic [OBJ_W-1:0]   object_res;
    logic [POS_W-1:0]   copy_offset;
    logic [LEN_W-1:0]   copy_length;
    logic [POS_W-1:0]   header_offset;
    logic [LEN_W-1:0]   header_fill;
    logic [OFF_W-1:0]   new_offset;
    logic [OFF_W-1:0]   consumed;
    logic               last;
  } result_t;

  typedef struct packed {
    logic [SHIFT_W-1:0] block_shift;
    logic [OFF_W-1:0]   data_limit;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic eval;
    logic check;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic go_check;
    logic rem_zero;
    logic fits;
    logic seg_last;
  } dp_status_t;

endpackage

// File: design/log_buffer_pool_and_append_core.sv
`timescale 1ns / 1ps
// Alloc, hold, release and rewind: one result word, registered after the object tables are read.
// Append: the object tables are read, then the walk steps one block at a time and checks the
// layout against the data limit, then one segment word per cycle.
// A new item is taken the cycle after the last result word is produced.
// Synchronous reset restores the free queue order, zero counts and offsets, default config.
// Result words are shown for one cycle under result_valid; the receiver cannot stall.

module log_buffer_pool_and_append_core import lbpa_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  item_t                 item,
  output result_t               result,
  output logic                  result_valid,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t st;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.block_shift <= SHIFT_RESET;
      cfg.data_limit  <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_BLOCK_SHIFT: cfg.block_shift <= cfg_data[SHIFT_W-1:0];
        CFG_DATA_LIMIT:  cfg.data_limit  <= cfg_data[OFF_W-1:0];
        default: begin
        end
      endcase
    end
  end

  lbpa_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .action (item.action),
    .st     (st),
    .cmd    (cmd),
    .busy   (busy)
  );

  lbpa_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .item         (item),
    .cfg          (cfg),
    .st           (st),
    .result       (result),
    .result_valid (result_valid)
  );

endmodule

// File: design/lbpa_ctrl.sv
`timescale 1ns / 1ps

module lbpa_ctrl import lbpa_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [2:0] action,
  input  dp_status_t st,
  output dp_cmd_t    cmd,
  output logic       busy
);

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    case (state)
      S_IDLE: begin
        busy = 1'b0;
        // drop undefined action codes without a result
        if (start && (action inside {ACT_ALLOC, ACT_HOLD, ACT_RELEASE, ACT_APPEND,
                                     ACT_REWIND})) begin
          cmd.load   = 1'b1;
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
        state_next = st.go_check ? S_CHECK : S_IDLE;
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        if (st.rem_zero) begin
          state_next = st.fits ? S_EMIT : S_IDLE;
        end
      end
      S_EMIT: begin
        cmd.emit = 1'b1;
        if (st.seg_last) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: design/lbpa_datapath.sv
`timescale 1ns / 1ps

module lbpa_datapath import lbpa_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  dp_cmd_t    cmd,
  input  item_t      item,
  input  cfg_t       cfg,
  output dp_status_t st,
  output result_t    result,
  output logic       result_valid
);

  // Object tables: refcount valid bits mark objects never allocated, and the
  // first alloc of an object clears its offset entry
  logic [OBJ_W-1:0]   q_mem   [NUM_OBJECTS];
  logic [REF_W-1:0]   ref_mem [NUM_OBJECTS];
  logic [OFF_W-1:0]   off_mem [NUM_OBJECTS];
  logic [NUM_OBJECTS-1:0] ref_vld;
  logic               q_wrap;

  logic [OBJ_W-1:0] q_rd;
  logic [REF_W-1:0] ref_rd;
  logic [OFF_W-1:0] off_rd;
  logic             q_vld_rd, ref_vld_rd;

  // Free queue pointers
  logic [IDX_W-1:0]  head, head_next;
  logic [IDX_W-1:0]  tail, tail_next;
  logic [FREE_W-1:0] free_cnt, free_cnt_next;

  // Item and walk registers
  logic [2:0]         act_q;
  logic [OBJ_W-1:0]   obj_q;
  logic [COUNT_W-1:0] count_q;
  logic               mark_q;
  logic [OFF_W-1:0]   off_q;
  logic [OFF_W-1:0]   end_q;
  logic [CUR_W-1:0]   cur, hdr;
  logic [COUNT_W-1:0] rem;
  logic [SEG_W-1:0]   seg_k;

  logic [CUR_W-1:0]   cur_next, hdr_next;
  logic [COUNT_W-1:0] rem_next;
  logic [SEG_W-1:0]   seg_k_next;
  logic [OFF_W-1:0]   off_q_next, end_q_next;

  // Write ports
  logic               q_we;
  logic               ref_we;
  logic [IDX_W-1:0]   ref_wa;
  logic [REF_W-1:0]   ref_wd;
  logic               off_we;
  logic [IDX_W-1:0]   off_wa;
  logic [OFF_W-1:0]   off_wd;

  result_t res_next;
  logic    res_valid_next;

  // Block geometry from the configuration
  logic [SHIFT_W-1:0] shift;
  logic [BSZ_W-1:0]   bsz;
  logic [MASK_W-1:0]  mask;
  logic [OFF_W-1:0]   limit;

  // Effective table contents and step values
  logic [OBJ_W-1:0]   q_out;
  logic [REF_W-1:0]   ref_cur;
  logic [OFF_W-1:0]   off_cur;
  logic               held;
  logic               ref_seen;
  logic [MASK_W-1:0]  cur_low, end_low;
  logic [BSZ_W-1:0]   room;
  logic [LEN_W-1:0]   step_len;
  logic [COUNT_W-1:0] rem_after;
  logic [CUR_W-1:0]   cur_after;
  logic               seg_more;
  logic [LEN_W-1:0]   fill_last;
  logic [IDX_W-1:0]   obj_idx;

  assign shift = (cfg.block_shift < SHIFT_MIN) ? SHIFT_MIN :
                 (cfg.block_shift > SHIFT_MAX) ? SHIFT_MAX : cfg.block_shift;
  assign bsz   = BSZ_W'(1) << shift;
  assign mask  = MASK_W'(bsz - BSZ_W'(1));
  assign limit = (cfg.data_limit > LIMIT_CAP) ? LIMIT_CAP : cfg.data_limit;

  assign obj_idx  = obj_q[IDX_W-1:0];
  assign q_out    = q_vld_rd ? q_rd : OBJ_W'(head);
  assign ref_cur  = ref_vld_rd ? ref_rd : '0;
  assign off_cur  = off_rd;
  assign ref_seen = ref_vld[q_out[IDX_W-1:0]];
  assign held     = ((OBJ_W + 1)'(obj_q) < (OBJ_W + 1)'(NUM_OBJECTS)) && (ref_cur != '0);

  // One block step: bytes that fit in the rest of the current block
  assign cur_low   = cur[MASK_W-1:0] & mask;
  assign room      = bsz - BSZ_W'(cur_low);
  assign step_len  = (COUNT_W'(room) > rem) ? LEN_W'(rem) : room;
  assign rem_after = rem - COUNT_W'(step_len);
  assign cur_after = cur + CUR_W'(step_len);
  assign seg_more  = (rem_after != '0) && (seg_k != SEG_W'(MAX_SEGS - 1));
  assign end_low   = cur_after[MASK_W-1:0] & mask;
  assign fill_last = (end_low != '0) ? LEN_W'(end_low) : bsz;

  assign st.go_check = (act_q == ACT_APPEND) && held;
  assign st.rem_zero = (rem == '0);
  assign st.fits     = (cur <= CUR_W'(limit));
  assign st.seg_last = !seg_more;

  // Table reads and writes; queue slots below the tail or after a wrap hold pushed words
  always_ff @(posedge clk) begin
    q_rd       <= q_mem[head];
    q_vld_rd   <= q_wrap || (head < tail);
    ref_rd     <= ref_mem[item.object[IDX_W-1:0]];
    ref_vld_rd <= ref_vld[item.object[IDX_W-1:0]];
    off_rd     <= off_mem[item.object[IDX_W-1:0]];
    if (q_we) begin
      q_mem[tail] <= obj_q;
    end
    if (ref_we) begin
      ref_mem[ref_wa] <= ref_wd;
    end
    if (off_we) begin
      off_mem[off_wa] <= off_wd;
    end
  end

  // Control state: valid bits, queue pointers, result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      ref_vld      <= '0;
      q_wrap       <= 1'b0;
      head         <= '0;
      tail         <= '0;
      free_cnt     <= FREE_W'(NUM_OBJECTS);
      result_valid <= 1'b0;
    end else begin
      if (q_we && (tail == IDX_W'(NUM_OBJECTS - 1))) begin
        q_wrap <= 1'b1;
      end
      if (ref_we) begin
        ref_vld[ref_wa] <= 1'b1;
      end
      head         <= head_next;
      tail         <= tail_next;
      free_cnt     <= free_cnt_next;
      result_valid <= res_valid_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_q   <= item.action;
      obj_q   <= item.object;
      count_q <= item.count;
      mark_q  <= item.mark_empty;
    end
    cur    <= cur_next;
    hdr    <= hdr_next;
    rem    <= rem_next;
    seg_k  <= seg_k_next;
    off_q  <= off_q_next;
    end_q  <= end_q_next;
    result <= res_next;
  end

  // Per-cycle actions
  always_comb begin
    head_next      = head;
    tail_next      = tail;
    free_cnt_next  = free_cnt;
    cur_next       = cur;
    hdr_next       = hdr;
    rem_next       = rem;
    seg_k_next     = seg_k;
    off_q_next     = off_q;
    end_q_next     = end_q;
    q_we           = 1'b0;
    ref_we         = 1'b0;
    ref_wa         = obj_idx;
    ref_wd         = ref_cur;
    off_we         = 1'b0;
    off_wa         = obj_idx;
    off_wd         = '0;
    res_next       = '0;
    res_next.status     = ST_OK;
    res_next.object_res = obj_q;
    res_next.last       = 1'b1;
    res_valid_next = 1'b0;

    if (cmd.eval) begin
      off_q_next = off_cur;
      // start the fit check from the current write offset
      cur_next   = CUR_W'(off_cur) +
                   (((off_cur[MASK_W-1:0] & mask) == '0) ? CUR_W'(HEADER_BYTES) : '0);
      rem_next   = count_q;
      res_valid_next = 1'b1;
      if (act_q == ACT_ALLOC) begin
        if (free_cnt == '0) begin
          res_next.status     = ST_POOL_EMPTY;
          res_next.object_res = '0;
        end else begin
          res_next.object_res = q_out;
          ref_we        = 1'b1;
          ref_wa        = q_out[IDX_W-1:0];
          ref_wd        = REF_W'(1);
          head_next     = (head == IDX_W'(NUM_OBJECTS - 1)) ? '0 : head + IDX_W'(1);
          free_cnt_next = free_cnt - FREE_W'(1);
          // clear the offset of an object handed out for the first time
          if (!ref_seen) begin
            off_we = 1'b1;
            off_wa = q_out[IDX_W-1:0];
            off_wd = '0;
          end
        end
      end else if (!held) begin
        res_next.status = ST_NOT_HELD;
      end else begin
        case (act_q)
          ACT_HOLD: begin
            if (ref_cur == REF_MAX) begin
              res_next.status = ST_SATURATED;
            end else begin
              ref_we = 1'b1;
              ref_wd = ref_cur + REF_W'(1);
            end
          end
          ACT_RELEASE: begin
            ref_we = 1'b1;
            ref_wd = ref_cur - REF_W'(1);
            // return the object to the queue tail when the last holder lets go
            if ((ref_cur == REF_W'(1)) && (free_cnt < FREE_W'(NUM_OBJECTS))) begin
              q_we          = 1'b1;
              tail_next     = (tail == IDX_W'(NUM_OBJECTS - 1)) ? '0 : tail + IDX_W'(1);
              free_cnt_next = free_cnt + FREE_W'(1);
            end
          end
          ACT_REWIND: begin
            off_we = 1'b1;
            off_wd = '0;
          end
          ACT_APPEND: begin
            res_valid_next = 1'b0;
          end
          default: begin
            res_valid_next = 1'b0;
          end
        endcase
      end
    end

    if (cmd.check) begin
      if (rem == '0) begin
        if (cur > CUR_W'(limit)) begin
          res_next.status     = ST_NO_SPACE;
          res_next.new_offset = off_q;
          res_valid_next      = 1'b1;
        end else begin
          // layout fits: rewind the walk for segment output
          end_q_next = OFF_W'(cur);
          cur_next   = CUR_W'(off_q) +
                       (((off_q[MASK_W-1:0] & mask) == '0) ? CUR_W'(HEADER_BYTES) : '0);
          hdr_next   = CUR_W'(off_q) & ~CUR_W'(mask);
          rem_next   = count_q;
          seg_k_next = '0;
        end
      end else begin
        // advance one block, adding a header when payload continues
        rem_next = rem_after;
        cur_next = cur_after + ((rem_after != '0) ? CUR_W'(HEADER_BYTES) : '0);
      end
    end

    if (cmd.emit) begin
      res_valid_next         = 1'b1;
      res_next.copy_offset   = cur[POS_W-1:0];
      res_next.copy_length   = step_len;
      res_next.header_offset = hdr[POS_W-1:0];
      res_next.new_offset    = end_q;
      res_next.consumed      = end_q - off_q;
      res_next.last          = !seg_more;
      if (seg_more) begin
        res_next.header_fill = mark_q ? '0 : LEN_W'(bsz);
        hdr_next   = cur_after;
        cur_next   = cur_after + CUR_W'(HEADER_BYTES);
        rem_next   = rem_after;
        seg_k_next = seg_k + SEG_W'(1);
      end else begin
        res_next.header_fill = mark_q ? '0 : fill_last;
        off_we = 1'b1;
        off_wd = end_q;
      end
    end
  end

endmodule
